// ----- rtl/rsol_pkg.sv -----
// Shared types and constants for the ring of sized entries with offset lookup.
// Used by rsol_ctrl, rsol_dp and the top level; no dependencies.
`default_nettype none

package rsol_pkg;

    localparam int HANDLE_W = 32;
    localparam int SIZE_W   = 16;
    localparam int OFFS_W   = 20;
    localparam int CIDX_W   = 4;
    localparam int COUNT_W  = 5;
    localparam int KIND_W   = 2;

    localparam int S_DATA_W = 88;  // handle, size, offset, index, byte
    localparam int M_DATA_W = 96;  // 89 bits of fields, zero filled

    localparam logic [OFFS_W-1:0] TOTAL_MAX = '1;

    typedef logic [KIND_W-1:0] t_kind;

    localparam t_kind KIND_ADD   = 2'd0;
    localparam t_kind KIND_FIND  = 2'd1;
    localparam t_kind KIND_TOTAL = 2'd2;
    localparam t_kind KIND_CMD   = 2'd3;

    // Result selection for the output register
    typedef logic [2:0] t_res;

    localparam t_res RES_ADD    = 3'd0;
    localparam t_res RES_HIT    = 3'd1;
    localparam t_res RES_ERR    = 3'd2;
    localparam t_res RES_TOTAL  = 3'd3;
    localparam t_res RES_CMD_OK = 3'd4;

    typedef struct packed {
        logic accept;  // latch operands, start the walk at the oldest entry
        logic add;     // store the new entry, advance slots
        logic step;    // accumulate current size, fetch next entry
        logic fin;     // load the output register
        t_res res;
    } t_cmd;

    typedef struct packed {
        logic at_end;    // walk index reached the held count
        logic fit_hit;   // sum + size passes the target offset
        logic idx_eq_k;  // walk index equals command index
        logic k_bad;     // command index not below held count
        logic nb_ok;     // command byte below current size
        logic out_free;  // output register can take a result
    } t_stat;

    function automatic logic [OFFS_W-1:0] sat_add(input logic [OFFS_W-1:0] a,
                                                  input logic [SIZE_W-1:0] b);
        logic [OFFS_W:0] s;
        s = {1'b0, a} + (OFFS_W+1)'(b);
        return s[OFFS_W] ? TOTAL_MAX : s[OFFS_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/rsol_ctrl.sv -----
// Sequencer: accepts one transaction, steps the datapath walk, issues the result.
// Depends on rsol_pkg.
`default_nettype none

module rsol_ctrl import rsol_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_s_valid,
    input  wire t_kind i_kind,
    output logic       o_s_ready,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_WALK = 1'b1;

    logic  r_state, n_state;
    t_kind r_kind, n_kind;
    logic  want_fin;
    t_res  want_res;

    always_comb begin
        n_state   = r_state;
        n_kind    = r_kind;
        o_cmd     = '0;
        o_s_ready = 1'b0;
        want_fin  = 1'b0;
        want_res  = RES_ADD;
        unique case (r_state)
            ST_IDLE: begin
                o_s_ready = 1'b1;
                if (i_s_valid) begin
                    o_cmd.accept = 1'b1;
                    o_cmd.add    = (i_kind == KIND_ADD);
                    n_kind       = i_kind;
                    n_state      = ST_WALK;
                end
            end
            ST_WALK: begin
                unique case (r_kind)
                    KIND_ADD: begin
                        want_fin = 1'b1;
                        want_res = RES_ADD;
                    end
                    KIND_FIND: begin
                        priority if (i_stat.at_end) begin
                            want_fin = 1'b1;
                            want_res = RES_ERR;
                        end else if (i_stat.fit_hit) begin
                            want_fin = 1'b1;
                            want_res = RES_HIT;
                        end else begin
                            o_cmd.step = 1'b1;
                        end
                    end
                    KIND_TOTAL: begin
                        if (i_stat.at_end) begin
                            want_fin = 1'b1;
                            want_res = RES_TOTAL;
                        end else begin
                            o_cmd.step = 1'b1;
                        end
                    end
                    KIND_CMD: begin
                        priority if (i_stat.k_bad) begin
                            want_fin = 1'b1;
                            want_res = RES_ERR;
                        end else if (i_stat.idx_eq_k) begin
                            want_fin = 1'b1;
                            want_res = i_stat.nb_ok ? RES_CMD_OK : RES_ERR;
                        end else begin
                            o_cmd.step = 1'b1;
                        end
                    end
                    default: begin
                        want_fin = 1'b1;
                        want_res = RES_ERR;
                    end
                endcase
                // hold until the output register frees up
                if (want_fin && i_stat.out_free) begin
                    o_cmd.fin = 1'b1;
                    o_cmd.res = want_res;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_kind  <= KIND_ADD;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/rsol_dp.sv -----
// Datapath: entry memories, ring slots and count, walk accumulator, output register.
// Depends on rsol_pkg; driven by rsol_ctrl commands.
`default_nettype none

module rsol_dp import rsol_pkg::*; #(
    parameter int DEPTH = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_cmd                i_cmd,
    input  wire logic [HANDLE_W-1:0] i_new_handle,
    input  wire logic [SIZE_W-1:0]   i_new_size,
    input  wire logic [OFFS_W-1:0]   i_byte_offset,
    input  wire logic [CIDX_W-1:0]   i_command_index,
    input  wire logic [SIZE_W-1:0]   i_command_byte,
    input  wire logic                i_m_ready,
    output t_stat                    o_stat,
    output logic                     o_m_valid,
    output logic                     o_m_status,
    output logic [M_DATA_W-1:0]      o_m_data
);

    localparam int SW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    function automatic logic [SW-1:0] next_slot(input logic [SW-1:0] s);
        return (s == SW'(DEPTH - 1)) ? '0 : s + 1'b1;
    endfunction

    logic [HANDLE_W-1:0] mem_handle [DEPTH];
    logic [SIZE_W-1:0]   mem_size   [DEPTH];

    logic [SW-1:0]       r_wr, r_rd, r_pos;
    logic [CW-1:0]       r_count, r_idx;
    logic [HANDLE_W-1:0] r_rd_handle;
    logic [SIZE_W-1:0]   r_rd_size;
    logic [OFFS_W-1:0]   r_sum, r_target;
    logic [CIDX_W-1:0]   r_k;
    logic [SIZE_W-1:0]   r_nb;
    logic                r_m_valid, r_m_status;
    logic [M_DATA_W-1:0] r_m_data;

    logic [SW-1:0]       rd_addr;
    logic [SW-1:0]       wr_next;
    logic [OFFS_W:0]     reach;
    logic [M_DATA_W-1:0] res_data;
    logic                res_status;
    logic [OFFS_W-1:0]   diff;

    assign rd_addr = i_cmd.accept ? r_rd : r_pos;
    assign wr_next = next_slot(r_wr);
    assign reach   = {1'b0, r_sum} + (OFFS_W+1)'(r_rd_size);
    assign diff    = r_target - r_sum;

    always_comb begin
        o_stat.at_end   = (r_idx >= r_count);
        o_stat.fit_hit  = (reach > {1'b0, r_target});
        o_stat.idx_eq_k = (8'(r_idx) == 8'(r_k));
        o_stat.k_bad    = (8'(r_k) >= 8'(r_count));
        o_stat.nb_ok    = (r_nb < r_rd_size);
        o_stat.out_free = !r_m_valid || i_m_ready;
    end

    // memories: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.add) begin
            mem_handle[r_wr] <= i_new_handle;
            mem_size[r_wr]   <= i_new_size;
        end
        if (i_cmd.accept || i_cmd.step) begin
            r_rd_handle <= mem_handle[rd_addr];
            r_rd_size   <= mem_size[rd_addr];
        end
    end

    // ring slots and held count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else if (i_cmd.add) begin
            r_wr <= wr_next;
            if (r_count == CW'(DEPTH)) begin
                r_rd <= wr_next;
            end else begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    // walk registers and operands
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_pos    <= next_slot(r_rd);
            r_idx    <= '0;
            r_sum    <= '0;
            r_target <= i_byte_offset;
            r_k      <= i_command_index;
            r_nb     <= i_command_byte;
        end else if (i_cmd.step) begin
            r_pos <= next_slot(r_pos);
            r_idx <= r_idx + 1'b1;
            r_sum <= sat_add(r_sum, r_rd_size);
        end
    end

    // result fields: handle, size, byte within, total, count
    always_comb begin
        res_data   = '0;
        res_status = 1'b0;
        unique case (i_cmd.res)
            RES_HIT: begin
                res_data[31:0]  = r_rd_handle;
                res_data[47:32] = r_rd_size;
                res_data[63:48] = diff[SIZE_W-1:0];
            end
            RES_TOTAL: begin
                res_data[83:64] = r_sum;
            end
            RES_CMD_OK: begin
                res_data[83:64] = sat_add(r_sum, r_nb);
            end
            RES_ERR: begin
                res_status = 1'b1;
            end
            default: begin
                res_status = 1'b0;
            end
        endcase
        res_data[88:84] = 5'(r_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (i_cmd.fin) begin
            r_m_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            r_m_data   <= res_data;
            r_m_status <= res_status;
        end
    end

    assign o_m_valid  = r_m_valid;
    assign o_m_status = r_m_status;
    assign o_m_data   = r_m_data;

endmodule

`default_nettype wire

// ----- rtl/ring_of_sized_entries_with_offset_lookup_unit.sv -----
// Top level of the ring of sized entries with offset lookup.
// Depends on rsol_pkg, rsol_ctrl and rsol_dp.
//
// Usage:
//   Slave stream carries one request per transaction. tuser is the kind
//   (add, find, total, command offset); tdata packs the operands. Master
//   stream returns exactly one result per request; tuser is the error flag.
//   An add passes from acceptance to the walk state, which loads its
//   result. Find, total and command offset walk the held entries from the
//   oldest, one entry per cycle through the registered memory read port,
//   then load the result. One request is in work at a time; the next is
//   taken the cycle after the result is loaded. The result sits in an
//   output register, so a new request is accepted while an earlier result
//   still waits on m_axis_tready. If the receiver stalls and the register
//   is occupied, the walk holds at its end. Reset (synchronous, active
//   low) empties the ring: slots and count go to zero and no result is
//   pending. Entry memories are not cleared; only held entries ever feed
//   a result.
`default_nettype none

module ring_of_sized_entries_with_offset_lookup_unit import rsol_pkg::*; #(
    parameter int DEPTH = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    // kind
    input  wire logic [KIND_W-1:0]   s_axis_tuser,
    // new_handle[31:0], new_size[47:32], byte_offset[67:48],
    // command_index[71:68], command_byte[87:72]
    input  wire logic [S_DATA_W-1:0] s_axis_tdata,
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    // status
    output logic                     m_axis_tuser,
    // found_handle[31:0], found_size[47:32], byte_within[63:48],
    // total_bytes[83:64], entry_count[88:84], zero fill above
    output logic [M_DATA_W-1:0]      m_axis_tdata
);

    t_cmd  cmd;
    t_stat stat;

    rsol_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .i_kind    (s_axis_tuser),
        .o_s_ready (s_axis_tready),
        .i_stat    (stat),
        .o_cmd     (cmd)
    );

    rsol_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_new_handle    (s_axis_tdata[31:0]),
        .i_new_size      (s_axis_tdata[47:32]),
        .i_byte_offset   (s_axis_tdata[67:48]),
        .i_command_index (s_axis_tdata[71:68]),
        .i_command_byte  (s_axis_tdata[87:72]),
        .i_m_ready       (m_axis_tready),
        .o_stat          (stat),
        .o_m_valid       (m_axis_tvalid),
        .o_m_status      (m_axis_tuser),
        .o_m_data        (m_axis_tdata)
    );

    // requests are never accepted back to back
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request accepted back to back");

    // a result is only loaded when the output register is free
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.fin |-> stat.out_free)
        else $error("pending result overwritten");

    // an error result carries only the entry count
    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[83:0] == '0)
        else $error("error result with nonzero fields");

    // a loaded result appears on the next cycle
    a_fin_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.fin |=> m_axis_tvalid)
        else $error("result lost");

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for ring_of_sized_entries_with_offset_lookup_unit.
// Depends on rsol_pkg and the top level; directed and random requests are checked
// against a behavioral ring model in this file or a directed row's typed-in answer.
`timescale 1ns / 1ps

module tb;
    import rsol_pkg::*;

    localparam int DEPTH     = 16;
    localparam int RAND_N    = 1250;
    localparam int DIR_N     = 23;
    localparam int SETTLE    = DEPTH + 8;
    localparam int MAX_SHOWN = 10;

    // result status codes carried on m_axis_tuser
    localparam logic ST_OK   = 1'b0;
    localparam logic ST_MISS = 1'b1;

    typedef struct packed {
        t_kind               kind;
        logic [HANDLE_W-1:0] handle;
        logic [SIZE_W-1:0]   size;
        logic [OFFS_W-1:0]   offs;
        logic [CIDX_W-1:0]   cidx;
        logic [SIZE_W-1:0]   cbyte;
    } t_req;

    typedef struct packed {
        logic                status;
        logic [HANDLE_W-1:0] fh;
        logic [SIZE_W-1:0]   fs;
        logic [SIZE_W-1:0]   bw;
        logic [OFFS_W-1:0]   tot;
        logic [COUNT_W-1:0]  cnt;
    } t_ans;

    // one row of the directed table: request, repeat count, and a typed-in
    // answer used instead of the model when hand_typed is set
    typedef struct packed {
        t_req       req;
        logic [4:0] reps;
        logic       hand_typed;
        t_ans       ans;
    } t_dir;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [KIND_W-1:0]   s_axis_tuser;   // kind
    // new_handle, new_size, byte_offset, command_index, command_byte
    logic [S_DATA_W-1:0] s_axis_tdata;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic                m_axis_tuser;   // status
    // found_handle, found_size, byte_within, total_bytes, entry_count, zero fill
    logic [M_DATA_W-1:0] m_axis_tdata;

    ring_of_sized_entries_with_offset_lookup_unit #(.DEPTH(DEPTH)) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #4 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // Ring model: entry stores, slots and full flag, as the block
    // should see them after every accepted transaction.
    // ---------------------------------------------------------------
    logic [HANDLE_W-1:0] hnd_mem [DEPTH];
    logic [SIZE_W-1:0]   len_mem [DEPTH];
    int unsigned         wr_slot   = 0;
    int unsigned         rd_slot   = 0;
    bit                  ring_full = 1'b0;

    t_ans ans_due [$];       // answers still owed by the block, oldest first
    bit   calm    = 1'b0;    // no idling on either side while set
    int   bad_cnt = 0;
    int   res_seen = 0;
    int   miss_seen = 0;
    int   wraps   = 0;
    int   kind_seen [4] = '{0, 0, 0, 0};

    function automatic int unsigned held_cnt();
        return ring_full ? DEPTH : (wr_slot + DEPTH - rd_slot) % DEPTH;
    endfunction

    // sum of the sizes of all held entries, not yet clipped
    function automatic int unsigned run_length();
        int unsigned acc;
        acc = 0;
        for (int unsigned i = 0; i < held_cnt(); i++) begin
            acc += len_mem[(rd_slot + i) % DEPTH];
        end
        return acc;
    endfunction

    function automatic logic [OFFS_W-1:0] clip20(input int unsigned v);
        return (v > TOTAL_MAX) ? TOTAL_MAX : OFFS_W'(v);
    endfunction

    // apply one request to the ring model and return the answer it causes
    function automatic t_ans ring_apply(input t_req r);
        t_ans        a;
        int unsigned pos, acc;
        bit          hit;
        a   = '0;
        pos = rd_slot;
        acc = 0;
        case (r.kind)
            KIND_ADD: begin
                hnd_mem[wr_slot] = r.handle;
                len_mem[wr_slot] = r.size;
                if (ring_full) begin
                    wraps++;
                end
                wr_slot = (wr_slot + 1) % DEPTH;
                // full ring: the oldest entry just got overwritten
                if (ring_full) begin
                    rd_slot = wr_slot;
                end
                if (rd_slot == wr_slot) begin
                    ring_full = 1'b1;
                end
            end
            KIND_FIND: begin
                hit = 1'b0;
                for (int unsigned i = 0; i < held_cnt() && !hit; i++) begin
                    // a zero-size entry can never satisfy this
                    if (acc + len_mem[pos] > r.offs) begin
                        hit  = 1'b1;
                        a.fh = hnd_mem[pos];
                        a.fs = len_mem[pos];
                        a.bw = SIZE_W'(r.offs - acc);
                    end else begin
                        acc += len_mem[pos];
                        pos  = (pos + 1) % DEPTH;
                    end
                end
                a.status = hit ? ST_OK : ST_MISS;
            end
            KIND_TOTAL: begin
                a.tot = clip20(run_length());
            end
            default: begin
                if (r.cidx >= held_cnt()) begin
                    a.status = ST_MISS;
                end else begin
                    for (int unsigned i = 0; i < r.cidx; i++) begin
                        acc += len_mem[pos];
                        pos  = (pos + 1) % DEPTH;
                    end
                    if (r.cbyte >= len_mem[pos]) begin
                        a.status = ST_MISS;
                    end else begin
                        a.tot = clip20(acc + r.cbyte);
                    end
                end
            end
        endcase
        a.cnt = COUNT_W'(held_cnt());
        return a;
    endfunction

    // idle length: mostly none or short, now and then a long one
    function automatic int unsigned idle_len();
        int unsigned p;
        p = $urandom_range(0, 99);
        if (calm || p < 55) begin
            return 0;
        end else if (p < 85) begin
            return $urandom_range(1, 3);
        end else if (p < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 40);
    endfunction

    // Drive one request; entered and left at a falling edge. The answer is
    // queued at the rising edge that completes the transaction.
    task automatic send_req(input t_req r, input bit hand_typed, input t_ans typed_ans);
        int unsigned gap;
        t_ans        want;
        gap = idle_len();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= r.kind;
        s_axis_tdata  <= {r.cbyte, r.cidx, r.offs, r.size, r.handle};
        do @(posedge i_clk); while (!s_axis_tready);
        want = ring_apply(r);
        if (hand_typed) begin
            want = typed_ans;
        end
        ans_due.push_back(want);
        kind_seen[r.kind]++;
        @(negedge i_clk);
    endtask

    // ---------------------------------------------------------------
    // Result side: random stalls, compare each transaction in order.
    // ---------------------------------------------------------------
    initial begin : sink
        int unsigned stall;
        m_axis_tready = 1'b0;
        @(negedge i_clk);
        forever begin
            stall = idle_len();
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_ans got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.status = m_axis_tuser;
            got.fh     = m_axis_tdata[31:0];
            got.fs     = m_axis_tdata[47:32];
            got.bw     = m_axis_tdata[63:48];
            got.tot    = m_axis_tdata[83:64];
            got.cnt    = m_axis_tdata[88:84];
            res_seen++;
            if (got.status == ST_MISS) begin
                miss_seen++;
            end
            if (ans_due.size() == 0) begin
                bad_cnt++;
                if (bad_cnt <= MAX_SHOWN) begin
                    $display("%0t: result with none outstanding: st=%0b h=%h s=%h b=%h t=%h c=%0d",
                             $realtime, got.status, got.fh, got.fs, got.bw, got.tot, got.cnt);
                end
            end else begin
                want = ans_due.pop_front();
                if (got !== want) begin
                    bad_cnt++;
                    if (bad_cnt <= MAX_SHOWN) begin
                        $display("%0t: result %0d mismatch", $realtime, res_seen);
                        $display("  expected st=%0b h=%h s=%h b=%h t=%h c=%0d",
                                 want.status, want.fh, want.fs, want.bw, want.tot, want.cnt);
                        $display("  actual   st=%0b h=%h s=%h b=%h t=%h c=%0d",
                                 got.status, got.fh, got.fs, got.bw, got.tot, got.cnt);
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus: directed table, then random requests.
    // ---------------------------------------------------------------
    t_dir dir_tab [DIR_N];

    initial begin : stim
        t_req        r;
        int unsigned pick, sel, span, sz;
        // empty ring: every lookup misses, total is zero
        dir_tab[0]  = '{'{KIND_TOTAL, 32'h0, 16'h0, 20'h0, 4'h0, 16'h0}, 5'd1, 1'b1,
                        '{ST_OK, 32'h0, 16'h0, 16'h0, 20'h0, 5'd0}};
        dir_tab[1]  = '{'{KIND_FIND, 32'h0, 16'h0, 20'h0, 4'h0, 16'h0}, 5'd1, 1'b1,
                        '{ST_MISS, 32'h0, 16'h0, 16'h0, 20'h0, 5'd0}};
        dir_tab[2]  = '{'{KIND_FIND, 32'h0, 16'h0, 20'hF_FFFF, 4'h0, 16'h0}, 5'd1, 1'b1,
                        '{ST_MISS, 32'h0, 16'h0, 16'h0, 20'h0, 5'd0}};
        dir_tab[3]  = '{'{KIND_CMD, 32'h0, 16'h0, 20'h0, 4'h0, 16'h0}, 5'd1, 1'b1,
                        '{ST_MISS, 32'h0, 16'h0, 16'h0, 20'h0, 5'd0}};
        // largest entry followed by an empty one
        dir_tab[4]  = '{'{KIND_ADD, 32'hFFFF_FFFF, 16'hFFFF, 20'h0, 4'h0, 16'h0}, 5'd1, 1'b1,
                        '{ST_OK, 32'h0, 16'h0, 16'h0, 20'h0, 5'd1}};
        dir_tab[5]  = '{'{KIND_ADD, 32'h0, 16'h0, 20'h0, 4'h0, 16'h0}, 5'd1, 1'b1,
                        '{ST_OK, 32'h0, 16'h0, 16'h0, 20'h0, 5'd2}};
        dir_tab[6]  = '{'{KIND_FIND, 32'h0, 16'h0, 20'h0, 4'h0, 16'h0}, 5'd1, 1'b1,
                        '{ST_OK, 32'hFFFF_FFFF, 16'hFFFF, 16'h0, 20'h0, 5'd2}};
        dir_tab[7]  = '{'{KIND_FIND, 32'h0, 16'h0, 20'h0_FFFE, 4'h0, 16'h0}, 5'd1, 1'b1,
                        '{ST_OK, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFE, 20'h0, 5'd2}};
        // end of run lands on the empty entry, which never matches
        dir_tab[8]  = '{'{KIND_FIND, 32'h0, 16'h0, 20'h0_FFFF, 4'h0, 16'h0}, 5'd1, 1'b1,
                        '{ST_MISS, 32'h0, 16'h0, 16'h0, 20'h0, 5'd2}};
        dir_tab[9]  = '{'{KIND_CMD, 32'h0, 16'h0, 20'h0, 4'h0, 16'hFFFE}, 5'd1, 1'b1,
                        '{ST_OK, 32'h0, 16'h0, 16'h0, 20'h0_FFFE, 5'd2}};
        // command byte past the entry, zero-size entry, index past the count
        dir_tab[10] = '{'{KIND_CMD, 32'h0, 16'h0, 20'h0, 4'h0, 16'hFFFF}, 5'd1, 1'b1,
                        '{ST_MISS, 32'h0, 16'h0, 16'h0, 20'h0, 5'd2}};
        dir_tab[11] = '{'{KIND_CMD, 32'h0, 16'h0, 20'h0, 4'h1, 16'h0}, 5'd1, 1'b1,
                        '{ST_MISS, 32'h0, 16'h0, 16'h0, 20'h0, 5'd2}};
        dir_tab[12] = '{'{KIND_CMD, 32'h0, 16'h0, 20'h0, 4'h2, 16'h0}, 5'd1, 1'b1,
                        '{ST_MISS, 32'h0, 16'h0, 16'h0, 20'h0, 5'd2}};
        dir_tab[13] = '{'{KIND_TOTAL, 32'h0, 16'h0, 20'h0, 4'h0, 16'h0}, 5'd1, 1'b1,
                        '{ST_OK, 32'h0, 16'h0, 16'h0, 20'h0_FFFF, 5'd2}};
        // fill the ring, then one more add overwrites the oldest entry
        dir_tab[14] = '{'{KIND_ADD, 32'hA5A5_A5A5, 16'h1, 20'h0, 4'h0, 16'h0}, 5'd14, 1'b0,
                        '0};
        dir_tab[15] = '{'{KIND_TOTAL, 32'h0, 16'h0, 20'h0, 4'h0, 16'h0}, 5'd1, 1'b0, '0};
        dir_tab[16] = '{'{KIND_ADD, 32'h5A5A_5A5A, 16'h8, 20'h0, 4'h0, 16'h0}, 5'd1, 1'b1,
                        '{ST_OK, 32'h0, 16'h0, 16'h0, 20'h0, 5'd16}};
        dir_tab[17] = '{'{KIND_FIND, 32'h0, 16'h0, 20'h0, 4'h0, 16'h0}, 5'd1, 1'b0, '0};
        dir_tab[18] = '{'{KIND_FIND, 32'h0, 16'h0, 20'hF_FFFF, 4'h0, 16'h0}, 5'd1, 1'b1,
                        '{ST_MISS, 32'h0, 16'h0, 16'h0, 20'h0, 5'd16}};
        dir_tab[19] = '{'{KIND_CMD, 32'h0, 16'h0, 20'h0, 4'hF, 16'h7}, 5'd1, 1'b0, '0};
        dir_tab[20] = '{'{KIND_CMD, 32'h0, 16'h0, 20'h0, 4'hF, 16'h8}, 5'd1, 1'b1,
                        '{ST_MISS, 32'h0, 16'h0, 16'h0, 20'h0, 5'd16}};
        // oldest is now the zero-size entry
        dir_tab[21] = '{'{KIND_CMD, 32'h0, 16'h0, 20'h0, 4'h0, 16'h0}, 5'd1, 1'b1,
                        '{ST_MISS, 32'h0, 16'h0, 16'h0, 20'h0, 5'd16}};
        dir_tab[22] = '{'{KIND_TOTAL, 32'h0, 16'h0, 20'h0, 4'h0, 16'h0}, 5'd1, 1'b0, '0};

        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser  = '0;
        s_axis_tdata  = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_tab[i]) begin
            repeat (dir_tab[i].reps) begin
                send_req(dir_tab[i].req, dir_tab[i].hand_typed, dir_tab[i].ans);
            end
        end

        // random part: mostly lookups aimed inside the held run, with
        // misses, edges and pure noise mixed in
        for (int n = 0; n < RAND_N; n++) begin
            calm     = (n >= 500 && n < 650);
            r.handle = $urandom;
            r.size   = SIZE_W'($urandom);
            r.offs   = OFFS_W'($urandom);
            r.cidx   = CIDX_W'($urandom);
            r.cbyte  = SIZE_W'($urandom);
            pick     = $urandom_range(0, 99);
            sel      = $urandom_range(0, 9);
            if (pick < 35) begin
                r.kind = KIND_ADD;
                if (sel < 5) begin
                    r.size = SIZE_W'($urandom_range(1, 64));
                end else if (sel == 5) begin
                    r.size = '0;
                end else if (sel == 6) begin
                    r.size = '1;
                end
            end else if (pick < 65) begin
                r.kind = KIND_FIND;
                span   = run_length();
                if (sel < 6 && span > 0) begin
                    r.offs = OFFS_W'($urandom_range(0, span - 1));
                end else if (sel < 8) begin
                    r.offs = clip20(span);
                end else if (sel == 8) begin
                    r.offs = '1;
                end
            end else if (pick < 77) begin
                r.kind = KIND_TOTAL;
            end else begin
                r.kind = KIND_CMD;
                if (sel < 7 && held_cnt() > 0) begin
                    r.cidx = CIDX_W'($urandom_range(0, held_cnt() - 1));
                    sz     = len_mem[(rd_slot + r.cidx) % DEPTH];
                    sel    = $urandom_range(0, 9);
                    if (sel < 6 && sz > 0) begin
                        r.cbyte = SIZE_W'($urandom_range(0, sz - 1));
                    end else if (sel < 8) begin
                        r.cbyte = SIZE_W'(sz);
                    end
                end
            end
            send_req(r, 1'b0, '0);
        end
        calm = 1'b0;
        s_axis_tvalid <= 1'b0;

        wait (ans_due.size() == 0);
        repeat (SETTLE) @(posedge i_clk);

        $display("requests: %0d add, %0d find, %0d total, %0d command offset",
                 kind_seen[KIND_ADD], kind_seen[KIND_FIND], kind_seen[KIND_TOTAL],
                 kind_seen[KIND_CMD]);
        $display("results checked: %0d (%0d miss/range errors), oldest overwritten %0d times",
                 res_seen, miss_seen, wraps);
        if (bad_cnt == 0 && ans_due.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("mismatches: %0d, answers outstanding: %0d", bad_cnt, ans_due.size());
            $display("simulation failed");
        end
        $finish;
    end

    // hard stop, well past the slowest legal run
    initial begin : watchdog
        #(5_000_000);
        $display("timeout, answers outstanding: %0d", ans_due.size());
        $display("simulation failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/rsol_pkg.sv
rtl/rsol_ctrl.sv
rtl/rsol_dp.sv
rtl/ring_of_sized_entries_with_offset_lookup_unit.sv
tb/tb.sv
